FILE: rtl/core/sha256_pkg.sv
// SHA-256 stream hasher package: types, constants and round functions.
// Used by sha256_round and sha256_stream_hasher_top; no dependencies.
package sha256_pkg;

    localparam int WordW = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic  start;
        logic  run;
        word_t w;
    } round_ctl_t;

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t v, input int s);
        return (v >> s) | (v << (WordW - s));
    endfunction

    function automatic word_t ssig0(input word_t p);
        return rotr(p, 7) ^ rotr(p, 18) ^ (p >> 3);
    endfunction

    function automatic word_t ssig1(input word_t q);
        return rotr(q, 17) ^ rotr(q, 19) ^ (q >> 10);
    endfunction

endpackage

FILE: rtl/core/sha256_round.sv
// SHA-256 round unit: working variables a..h and one round per cycle while ctl.run is set.
// Depends on sha256_pkg.
module sha256_round
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::round_ctl_t ctl,
    input  logic [5:0]             round_idx,
    input  sha256_pkg::word_t      chain [8],
    output sha256_pkg::word_t      vars [8]
);

    sha256_pkg::word_t v_reg [8];
    sha256_pkg::word_t v_next [8];
    sha256_pkg::word_t big0, big1, ch, maj, t1, t2;

    // one compression round
    always_comb
    begin
        big1 = sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
             ^ sha256_pkg::rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + sha256_pkg::round_k(round_idx) + ctl.w;
        big0 = sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
             ^ sha256_pkg::rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
        v_next = v_reg;
        if (ctl.start)
        begin
            v_next = chain;
        end
        else if (ctl.run)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    // working variables
    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign vars = v_reg;

    // rst_n unused for payload; kept on the port for uniform hookup
    logic unused_rst;
    assign unused_rst = rst_n;

endmodule

FILE: rtl/core/sha256_stream_hasher_top.sv
// SHA-256 stream hasher top level: byte intake, padding, schedule, digest out.
// Depends on sha256_pkg and sha256_round.
//
// A data word (one byte) is taken while the 64-byte block is not yet full.
// A byte that fills the block costs a compression (load, 64 rounds of the
// shared round unit, fold), during which in_ready is low. A word with last
// set pads the block and runs one or two more compressions, then the eight
// digest words are offered one per cycle on the output, holding while out_ready
// is low; the next message word is taken once the last digest word has left.
// The message schedule is a 16-word shift window.
module sha256_stream_hasher_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha256_pkg::state_t state_reg, state_next;
    sha256_pkg::word_t  chain_reg [8];
    sha256_pkg::word_t  chain_next [8];
    sha256_pkg::word_t  sched_reg [16];
    sha256_pkg::word_t  sched_next [16];
    sha256_pkg::word_t  vars [8];
    sha256_pkg::word_t  w_new;
    logic [60:0] count_reg, count_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        final_reg, final_next;   // compression belongs to padding
    logic        second_reg, second_next; // a length-only block must follow
    logic        end_reg, end_next;       // accepted word carried last
    logic [2:0]  emit_reg, emit_next;
    logic        acc;
    sha256_pkg::round_ctl_t ctl;
    logic [5:0]  pos;
    logic [63:0] bits;

    assign acc      = in_valid && in_ready;
    assign in_ready = (state_reg == sha256_pkg::ST_IDLE);
    assign pos      = count_reg[5:0];
    assign bits     = {count_reg, 3'b000};

    // schedule word for the current round
    assign w_new = sched_reg[0] + sha256_pkg::ssig0(sched_reg[1]) + sched_reg[9]
                 + sha256_pkg::ssig1(sched_reg[14]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE:
                if (acc && has_byte && pos == 6'd63)
                    state_next = sha256_pkg::ST_LOAD;
                else if (acc && last)
                    state_next = sha256_pkg::ST_PAD;
            sha256_pkg::ST_PAD:   state_next = sha256_pkg::ST_LOAD;
            sha256_pkg::ST_LOAD:  state_next = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND:
                if (rnd_reg == 6'd63) state_next = sha256_pkg::ST_FOLD;
            sha256_pkg::ST_FOLD:
                if (!final_reg)
                    state_next = end_reg ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
                else if (second_reg)
                    state_next = sha256_pkg::ST_LOAD;
                else
                    state_next = sha256_pkg::ST_EMIT;
            sha256_pkg::ST_EMIT:
                if (out_ready && emit_reg == 3'd7) state_next = sha256_pkg::ST_IDLE;
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // datapath and control registers' next values
    always_comb
    begin
        chain_next  = chain_reg;
        sched_next  = sched_reg;
        count_next  = count_reg;
        rnd_next    = rnd_reg;
        final_next  = final_reg;
        second_next = second_reg;
        end_next    = end_reg;
        emit_next   = emit_reg;
        ctl.start   = 1'b0;
        ctl.run     = 1'b0;
        ctl.w       = (rnd_reg < 6'd16) ? sched_reg[rnd_reg[3:0]] : w_new;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (acc)
                    end_next = last;
                if (acc && has_byte)
                begin
                    sched_next[pos[5:2]][8*(3-pos[1:0]) +: 8] = data_byte;
                    count_next = count_reg + 61'd1;
                end
            end
            sha256_pkg::ST_PAD:
            begin
                // 0x80 marker, zero tail, length if it fits
                for (int i = 0; i < 64; i++)
                begin
                    if (i == pos)
                        sched_next[i/4][8*(3-i%4) +: 8] = 8'h80;
                    else if (i > pos)
                        sched_next[i/4][8*(3-i%4) +: 8] = 8'h00;
                end
                final_next  = 1'b1;
                second_next = (pos >= 6'd56);
                if (pos < 6'd56)
                begin
                    sched_next[14] = bits[63:32];
                    sched_next[15] = bits[31:0];
                end
            end
            sha256_pkg::ST_LOAD:
            begin
                ctl.start = 1'b1;
                rnd_next  = 6'd0;
            end
            sha256_pkg::ST_ROUND:
            begin
                ctl.run  = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg >= 6'd16)
                begin
                    for (int i = 0; i < 15; i++)
                        sched_next[i] = sched_reg[i+1];
                    sched_next[15] = w_new;
                end
            end
            sha256_pkg::ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                    chain_next[i] = chain_reg[i] + vars[i];
                if (final_reg && second_reg)
                begin
                    for (int i = 0; i < 14; i++)
                        sched_next[i] = '0;
                    sched_next[14] = bits[63:32];
                    sched_next[15] = bits[31:0];
                    second_next = 1'b0;
                end
                emit_next = 3'd0;
            end
            sha256_pkg::ST_EMIT:
                if (out_ready)
                begin
                    emit_next = emit_reg + 3'd1;
                    if (emit_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                            chain_next[i] = sha256_pkg::init_h(3'(i));
                        count_next = '0;
                        final_next = 1'b0;
                    end
                end
            default: ;
        endcase
    end

    // Schedule window note: rounds 0..15 read sched_reg directly by index;
    // from round 16 the window shifts so entry 0 holds w[t-16] at round t.

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha256_pkg::ST_IDLE;
            count_reg  <= '0;
            rnd_reg    <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            end_reg    <= 1'b0;
            emit_reg   <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha256_pkg::init_h(3'(i));
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rnd_reg    <= rnd_next;
            final_reg  <= final_next;
            second_reg <= second_next;
            end_reg    <= end_next;
            emit_reg   <= emit_next;
            chain_reg  <= chain_next;
        end
    end

    // message block and schedule window
    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
    end

    sha256_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .round_idx (rnd_reg),
        .chain     (chain_reg),
        .vars      (vars)
    );

    // digest output
    assign out_valid   = (state_reg == sha256_pkg::ST_EMIT);
    assign digest_word = chain_reg[emit_reg];
    assign word_index  = emit_reg;
    assign last_word   = (emit_reg == 3'd7);

    // assertions
    a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha256_pkg::ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_round_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha256_pkg::ST_ROUND && rnd_reg == 6'd63)
        |=> state_reg == sha256_pkg::ST_FOLD)
        else $error("round count lost");
    a_emit_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=> (out_valid
        && word_index == $past(word_index) + 3'd1))
        else $error("digest word skipped");
    a_count_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> count_reg == '0)
        else $error("byte count not cleared");

endmodule
